/* hw/rtl/ippc_pkg.sv */
// Shared types and constants for the item pair Pearson correlation block.
// No dependencies; the top level, the controller and the datapath import this package.
package ippc_pkg;

  localparam int NUM_ITEMS_DEF   = 64;
  localparam int MAX_RATINGS_DEF = 32;

  localparam logic [1:0] FUNC_RATING = 2'd0;
  localparam logic [1:0] FUNC_FLUSH  = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [2:0]  SCORE_MAX = 3'd5;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  // Operand width of the serial multiplier; every product term fits 53 bits.
  localparam int MW         = 54;
  localparam int DIV_STEPS  = 28;
  localparam int SQRT_STEPS = 16;
  localparam logic [31:0] Q_ONE = 32'd16384;

  typedef struct packed {
    logic [23:0] count;
    logic [26:0] first;
    logic [26:0] second;
    logic [28:0] product;
    logic [28:0] first_sq;
    logic [28:0] second_sq;
  } sums_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_APPEND, ST_ACC_START, ST_LAT_I, ST_PAIR_IDX, ST_PAIR_UPD,
    ST_ACC_END, ST_Q_RD, ST_Q_CHK, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_INIT, ST_DIV,
    ST_SQ_INIT, ST_SQ, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_P1, MUL_P2, MUL_P3, MUL_P4, MUL_P5, MUL_P6, MUL_P7, MUL_P8
  } mul_sel_t;

  typedef struct packed {
    logic     latch;
    logic     clr_we;
    logic     append;
    logic     i_first;
    logic     i_inc;
    logic     lat_i;
    logic     j_inc;
    logic     pair_rd;
    logic     pair_we;
    logic     len_clr;
    logic     q_rd;
    logic     load_sums;
    logic     mul_go;
    logic     mul_store;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     sq_init;
    logic     sq_step;
    logic     out_hit;
    logic     out_miss;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic user_diff;
    logic len_lt2;
    logic j_last;
    logic i_last;
    logic lat_rec;
    logic hit;
    logic mul_done;
    logic r_ge_g;
    logic div_last;
    logic sq_last;
  } status_t;

endpackage

/* hw/rtl/item_pair_pearson_correlation.sv */
// Top level of the item pair Pearson correlation block: controller plus datapath.
// Depends on ippc_pkg, ippc_ctrl, ippc_dp (and through it ippc_ram, ippc_mul).
//
//   channel   handshake          payload
//   input     start / busy       func, user_id, item_a, item_b, score
//   result    done (one cycle)   found, pair_count, correlation
//
// A rating record of the current user is appended to the rating buffer. A user
// change or a flush walks every buffered pair with a read-modify-write of the
// pair sums memory, then a pending rating record is stored in the buffer.
// A query runs 8 products through the serial multiplier, then 28 divide steps
// (skipped when num squared is not below vx times vy) and 16 square root steps;
// a miss skips the arithmetic. After reset the sums memory is cleared, one entry
// a cycle (NUM_ITEMS squared entries, 4096 by default), with busy high.
// The receiver cannot stall results.
module item_pair_pearson_correlation #(
  parameter int NUM_ITEMS        = ippc_pkg::NUM_ITEMS_DEF,
  parameter int MAX_USER_RATINGS = ippc_pkg::MAX_RATINGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         func,
  input  logic [31:0]        user_id,
  input  logic [6:0]         item_a,
  input  logic [6:0]         item_b,
  input  logic [2:0]         score,
  output logic               busy,
  output logic               done,
  output logic               found,
  output logic [23:0]        pair_count,
  output logic signed [15:0] correlation
);
  import ippc_pkg::*;

  cmd_t    cmd;
  status_t st;

  ippc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (func),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  ippc_dp #(
    .NUM_ITEMS       (NUM_ITEMS),
    .MAX_USER_RATINGS(MAX_USER_RATINGS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .user_id    (user_id),
    .item_a     (item_a),
    .item_b     (item_b),
    .score      (score),
    .cmd        (cmd),
    .st         (st),
    .done       (done),
    .found      (found),
    .pair_count (pair_count),
    .correlation(correlation)
  );

endmodule

/* hw/rtl/ippc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ippc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ippc_mul.sv */
// Shift-and-add multiplier, one operand bit per cycle.
// No package dependencies.
module ippc_mul #(
  parameter int WIDTH = 54
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic               done,
  output logic [2*WIDTH-1:0] prod
);

  localparam int CW = $clog2(WIDTH);

  logic [2*WIDTH-1:0] a_sh;
  logic [WIDTH-1:0]   b_sh;
  logic [CW-1:0]      cnt;
  logic               run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(WIDTH - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      a_sh <= (2*WIDTH)'(a);
      b_sh <= b;
    end else if (run) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= {a_sh[2*WIDTH-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[WIDTH-1:1]};
    end
  end

endmodule

/* hw/rtl/ippc_ctrl.sv */
// Controller state machine: sequences record buffering, pair accumulation,
// the clearing pass and the query arithmetic. Depends on ippc_pkg.
module ippc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  ippc_pkg::status_t st,
  output ippc_pkg::cmd_t    cmd,
  output logic              busy
);
  import ippc_pkg::*;

  state_t   state, state_next;
  mul_sel_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      step  <= MUL_P1;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_CLR:       if (st.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          priority if (func == FUNC_RATING) begin
            state_next = st.user_diff ? ST_ACC_START : ST_APPEND;
          end else if (func == FUNC_FLUSH) begin
            state_next = ST_ACC_START;
          end else if (func == FUNC_QUERY) begin
            state_next = ST_Q_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_APPEND:    state_next = ST_IDLE;
      ST_ACC_START: state_next = st.len_lt2 ? ST_ACC_END : ST_LAT_I;
      ST_LAT_I:     state_next = ST_PAIR_IDX;
      ST_PAIR_IDX:  state_next = ST_PAIR_UPD;
      ST_PAIR_UPD: begin
        priority if (!st.j_last) state_next = ST_PAIR_IDX;
        else if (!st.i_last)     state_next = ST_LAT_I;
        else                     state_next = ST_ACC_END;
      end
      ST_ACC_END:   state_next = st.lat_rec ? ST_APPEND : ST_IDLE;
      ST_Q_RD:      state_next = ST_Q_CHK;
      ST_Q_CHK: begin
        step_next  = MUL_P1;
        state_next = st.hit ? ST_MUL_GO : ST_IDLE;
      end
      ST_MUL_GO:    state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (st.mul_done) begin
          if (step == MUL_P8) begin
            state_next = ST_DIV_INIT;
          end else begin
            step_next  = mul_sel_t'(3'(step) + 3'd1);
            state_next = ST_MUL_GO;
          end
        end
      end
      ST_DIV_INIT:  state_next = st.r_ge_g ? ST_SQ_INIT : ST_DIV;
      ST_DIV:       if (st.div_last) state_next = ST_SQ_INIT;
      ST_SQ_INIT:   state_next = ST_SQ;
      ST_SQ:        if (st.sq_last) state_next = ST_OUT;
      ST_OUT:       state_next = ST_IDLE;
      default:      state_next = ST_CLR;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = step;
    unique case (state)
      ST_CLR:       cmd.clr_we  = 1'b1;
      ST_IDLE:      cmd.latch   = start;
      ST_APPEND:    cmd.append  = 1'b1;
      ST_ACC_START: cmd.i_first = !st.len_lt2;
      ST_LAT_I:     cmd.lat_i   = 1'b1;
      ST_PAIR_IDX:  cmd.pair_rd = 1'b1;
      ST_PAIR_UPD: begin
        cmd.pair_we = 1'b1;
        cmd.j_inc   = !st.j_last;
        cmd.i_inc   = st.j_last && !st.i_last;
      end
      ST_ACC_END:   cmd.len_clr = 1'b1;
      ST_Q_RD:      cmd.q_rd    = 1'b1;
      ST_Q_CHK: begin
        cmd.load_sums = st.hit;
        cmd.out_miss  = !st.hit;
      end
      ST_MUL_GO:    cmd.mul_go    = 1'b1;
      ST_MUL_WAIT:  cmd.mul_store = st.mul_done;
      ST_DIV_INIT:  cmd.div_init  = 1'b1;
      ST_DIV:       cmd.div_step  = 1'b1;
      ST_SQ_INIT:   cmd.sq_init   = 1'b1;
      ST_SQ:        cmd.sq_step   = 1'b1;
      ST_OUT:       cmd.out_hit   = 1'b1;
      default:      cmd.clr_we    = 1'b0;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

/* hw/rtl/ippc_dp.sv */
// Datapath: rating buffer, pair sums memory, serial multiplier, restoring
// divider and integer square root. Depends on ippc_pkg, ippc_ram, ippc_mul.
module ippc_dp #(
  parameter int NUM_ITEMS        = ippc_pkg::NUM_ITEMS_DEF,
  parameter int MAX_USER_RATINGS = ippc_pkg::MAX_RATINGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         func,
  input  logic [31:0]        user_id,
  input  logic [6:0]         item_a,
  input  logic [6:0]         item_b,
  input  logic [2:0]         score,
  input  ippc_pkg::cmd_t     cmd,
  output ippc_pkg::status_t  st,
  output logic               done,
  output logic               found,
  output logic [23:0]        pair_count,
  output logic signed [15:0] correlation
);
  import ippc_pkg::*;

  localparam int IW    = $clog2(NUM_ITEMS);
  localparam int PAIRS = NUM_ITEMS * NUM_ITEMS;
  localparam int AW    = $clog2(PAIRS);
  localparam int PAW   = $clog2(MAX_USER_RATINGS);
  localparam int LW    = $clog2(MAX_USER_RATINGS + 1);
  localparam int SUMW  = $bits(sums_t);

  // Latched input item.
  logic [1:0]  in_func;
  logic [31:0] in_user;
  logic [6:0]  in_a, in_b;
  logic [2:0]  in_score;
  logic [31:0] cur_user;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_func  <= func;
      in_user  <= user_id;
      in_a     <= item_a;
      in_b     <= item_b;
      in_score <= score;
    end
  end

  function automatic logic item_ok(logic [6:0] v);
    return (v != 7'd0) && (13'(v) <= 13'(NUM_ITEMS));
  endfunction

  // Rating buffer.
  logic [LW-1:0]   len;
  logic [PAW-1:0]  i, j, i_n, j_n;
  logic [IW-1:0]   item_i;
  logic [2:0]      score_i;
  logic [IW+2:0]   pend_wdata, pend_rdata;
  logic [PAW-1:0]  pend_raddr;
  logic            pend_we;
  logic [2:0]      sat_score;

  assign sat_score  = (in_score > SCORE_MAX) ? SCORE_MAX : in_score;
  assign pend_we    = cmd.append && item_ok(in_a) && (len < LW'(MAX_USER_RATINGS));
  assign pend_wdata = {IW'(in_a - 7'd1), sat_score};

  always_comb begin
    i_n = i;
    j_n = j;
    if (cmd.i_first) i_n = PAW'(1);
    if (cmd.i_inc)   i_n = i + PAW'(1);
    if (cmd.lat_i)   j_n = '0;
    if (cmd.j_inc)   j_n = j + PAW'(1);
  end

  assign pend_raddr = (cmd.i_first || cmd.i_inc) ? i_n : j_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      cur_user <= '0;
    end else begin
      if (cmd.len_clr) begin
        len <= '0;
      end else if (pend_we) begin
        len <= len + LW'(1);
      end
      if (cmd.append) begin
        cur_user <= in_user;
      end
    end
  end

  always_ff @(posedge clk) begin
    i <= i_n;
    j <= j_n;
    if (cmd.lat_i) begin
      item_i  <= pend_rdata[IW+2:3];
      score_i <= pend_rdata[2:0];
    end
  end

  ippc_ram #(.WIDTH(IW + 3), .DEPTH(MAX_USER_RATINGS)) u_pend (
    .clk  (clk),
    .we   (pend_we),
    .waddr(PAW'(len)),
    .wdata(pend_wdata),
    .raddr(pend_raddr),
    .rdata(pend_rdata)
  );

  // Pair ordering: the larger item index is first; ties keep the later rating first.
  logic [IW-1:0] item_j, pa, pb;
  logic [2:0]    sx_c, sy_c, px, py;
  logic [AW-1:0] pidx_c, pidx;

  assign item_j = pend_rdata[IW+2:3];

  always_comb begin
    if (item_i < item_j) begin
      pa = item_j; pb = item_i; sx_c = pend_rdata[2:0]; sy_c = score_i;
    end else begin
      pa = item_i; pb = item_j; sx_c = score_i; sy_c = pend_rdata[2:0];
    end
    pidx_c = AW'(pa) * AW'(NUM_ITEMS) + AW'(pb);
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_rd) begin
      pidx <= pidx_c;
      px   <= sx_c;
      py   <= sy_c;
    end
  end

  // Query index.
  logic [IW-1:0] qa, qb, qhi, qlo;
  logic [AW-1:0] qidx;
  logic          q_ok;

  assign qa   = IW'(in_a - 7'd1);
  assign qb   = IW'(in_b - 7'd1);
  assign qhi  = (qa < qb) ? qb : qa;
  assign qlo  = (qa < qb) ? qa : qb;
  assign qidx = AW'(qhi) * AW'(NUM_ITEMS) + AW'(qlo);
  assign q_ok = item_ok(in_a) && item_ok(in_b);

  // Pair sums memory with clearing pass after reset.
  logic [AW-1:0] clr_addr;
  sums_t         rd, upd;
  logic          sat;
  logic [4:0]    xy, xx, yy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign xy  = 5'(px) * 5'(py);
  assign xx  = 5'(px) * 5'(px);
  assign yy  = 5'(py) * 5'(py);
  assign sat = (rd.count == COUNT_MAX);

  always_comb begin
    upd.count     = rd.count + 24'd1;
    upd.first     = rd.first + 27'(px);
    upd.second    = rd.second + 27'(py);
    upd.product   = rd.product + 29'(xy);
    upd.first_sq  = rd.first_sq + 29'(xx);
    upd.second_sq = rd.second_sq + 29'(yy);
  end

  ippc_ram #(.WIDTH(SUMW), .DEPTH(PAIRS)) u_sums (
    .clk  (clk),
    .we   (cmd.clr_we || (cmd.pair_we && !sat)),
    .waddr(cmd.clr_we ? clr_addr : pidx),
    .wdata(cmd.clr_we ? SUMW'(0) : SUMW'(upd)),
    .raddr(cmd.q_rd ? qidx : pidx_c),
    .rdata(rd)
  );

  // Query arithmetic.
  sums_t                s;
  logic [MW-1:0]        ma, mb, tmp;
  logic [2*MW-1:0]      prod;
  logic                 mul_done;
  logic signed [55:0]   num, vx, vy;
  logic [MW-1:0]        mag;
  logic [2*MW-1:0]      r, g, r2;
  logic [28:0]          t;
  logic [31:0]          v, res, bitv, rb;
  logic [4:0]           iter;
  logic [14:0]          q;

  assign mag = MW'(num[55] ? -num : num);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_sel)
      MUL_P1: begin ma = MW'(s.count);  mb = MW'(s.product);   end
      MUL_P2: begin ma = MW'(s.first);  mb = MW'(s.second);    end
      MUL_P3: begin ma = MW'(s.count);  mb = MW'(s.first_sq);  end
      MUL_P4: begin ma = MW'(s.first);  mb = MW'(s.first);     end
      MUL_P5: begin ma = MW'(s.count);  mb = MW'(s.second_sq); end
      MUL_P6: begin ma = MW'(s.second); mb = MW'(s.second);    end
      MUL_P7: begin ma = mag;           mb = mag;              end
      MUL_P8: begin ma = MW'(vx);       mb = MW'(vy);          end
    endcase
  end

  ippc_mul #(.WIDTH(MW)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_go),
    .a    (ma),
    .b    (mb),
    .done (mul_done),
    .prod (prod)
  );

  assign r2 = {r[2*MW-2:0], 1'b0};
  assign rb = res + bitv;

  always_ff @(posedge clk) begin
    if (cmd.load_sums) begin
      s <= rd;
    end
    if (cmd.mul_store) begin
      unique case (cmd.mul_sel)
        MUL_P1, MUL_P3, MUL_P5: tmp <= MW'(prod);
        MUL_P2: num <= 56'(tmp) - 56'(prod);
        MUL_P4: vx  <= 56'(tmp) - 56'(prod);
        MUL_P6: vy  <= 56'(tmp) - 56'(prod);
        MUL_P7: r   <= prod;
        MUL_P8: g   <= prod;
      endcase
    end
    if (cmd.div_init) begin
      t    <= (r >= g) ? 29'h1000_0000 : 29'd0;
      iter <= '0;
    end
    if (cmd.div_step) begin
      iter <= iter + 5'd1;
      if (r2 >= g) begin
        r <= r2 - g;
        t <= {t[27:0], 1'b1};
      end else begin
        r <= r2;
        t <= {t[27:0], 1'b0};
      end
    end
    if (cmd.sq_init) begin
      v    <= 32'(t);
      res  <= '0;
      bitv <= 32'h4000_0000;
      iter <= '0;
    end
    if (cmd.sq_step) begin
      iter <= iter + 5'd1;
      bitv <= bitv >> 2;
      if (v >= rb) begin
        v   <= v - rb;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
    end
  end

  assign q = (res > Q_ONE) ? 15'(Q_ONE) : res[14:0];

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_hit || cmd.out_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_miss) begin
      found       <= 1'b0;
      pair_count  <= '0;
      correlation <= '0;
    end else if (cmd.out_hit) begin
      found      <= 1'b1;
      pair_count <= s.count;
      // A constant pair has no variance and reports zero correlation.
      if (vx[55] || vx == '0 || vy[55] || vy == '0) begin
        correlation <= '0;
      end else begin
        correlation <= num[55] ? -$signed(16'(q)) : $signed(16'(q));
      end
    end
  end

  // Status back to the controller.
  assign st.clr_last  = (clr_addr == AW'(PAIRS - 1));
  assign st.user_diff = (user_id != cur_user);
  assign st.len_lt2   = (len < LW'(2));
  assign st.j_last    = ((PAW+1)'(j) + (PAW+1)'(1)) == (PAW+1)'(i);
  assign st.i_last    = (LW'(i) + LW'(1)) == len;
  assign st.lat_rec   = (in_func == FUNC_RATING);
  assign st.hit       = q_ok && (rd.count != '0);
  assign st.mul_done  = mul_done;
  assign st.r_ge_g    = (r >= g);
  assign st.div_last  = (iter == 5'(DIV_STEPS - 1));
  assign st.sq_last   = (iter == 5'(SQRT_STEPS - 1));

endmodule
